FILE: src/rtphp_pkg.sv
// Shared types, codes and constants of the RTP header and extension parser.
// Used by the decoder, the result queue and the top level; depends on nothing.
`default_nettype none
package rtphp_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_AW          = $clog2(FIFO_DEPTH);

  // Configuration register indexes.
  localparam logic CFG_RTCP_LOW  = 1'b0;
  localparam logic CFG_RTCP_HIGH = 1'b1;

  // Record kinds.
  localparam logic [1:0] KIND_ELEMENT = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_VERSION   = 4'd2;
  localparam logic [3:0] ST_RTCP      = 4'd3;
  localparam logic [3:0] ST_CSRC      = 4'd4;
  localparam logic [3:0] ST_EXT       = 4'd5;
  localparam logic [3:0] ST_ZERO_PAD  = 4'd6;
  localparam logic [3:0] ST_PAD_OVF   = 4'd7;
  localparam logic [3:0] ST_PROFILE   = 4'd8;
  localparam logic [3:0] ST_ELEM_LEN  = 4'd9;

  // Element parse phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
  localparam logic [11:0] PROFILE_TWO_BYTE = 12'h100;
  localparam logic [1:0]  RTP_VERSION      = 2'd2;
  localparam logic [3:0]  ID_STOP          = 4'hF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_packet;
    logic [11:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [3:0]  status;
    logic [7:0]  element_id;
    logic [11:0] span_length;
    logic [10:0] span_offset;
    logic [7:0]  marker_and_type;
    logic [3:0]  csrc_count;
    logic [15:0] sequence_number;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [7:0]  padding_length;
    logic [4:0]  extension_profile;
  } out_item_t;

  // Up to two records produced by one byte; a single record sits in slot 0.
  typedef struct packed {
    logic      valid0;
    logic      valid1;
    out_item_t rec0;
    out_item_t rec1;
  } rec_pair_t;

endpackage
`default_nettype wire

FILE: src/rtphp_decode.sv
// Per-byte header and extension decoder: packet state registers and the
// record logic. Depends on rtphp_pkg.
`default_nettype none
module rtphp_decode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire rtphp_pkg::in_item_t item,
  input  wire logic [7:0]         rtcp_low,
  input  wire logic [7:0]         rtcp_high,
  output rtphp_pkg::rec_pair_t    recs
);
  import rtphp_pkg::*;

  typedef struct packed {
    logic [10:0] pos;
    logic [7:0]  hb0;
    logic [7:0]  hb1;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [18:0] ext_end;
    logic [15:0] profile;
    logic [1:0]  phase;
    logic [7:0]  el_id;
    logic [8:0]  left;
    logic [10:0] el_start;
    logic [3:0]  err;
    logic        stopped;
  } pstate_t;

  pstate_t     st, cur, st_next;
  logic        active, active_next;
  logic [11:0] plen, plen_cur, len_clamped;

  logic [7:0]  b;
  logic [10:0] p;
  logic [18:0] p18, hs18, plen18, hdr_end18;
  logic        ext, is_rtcp, prefix_ok, in_window, last, one_byte, take;
  logic [15:0] prof_new;
  logic [4:0]  prof_bits;
  logic [4:0]  len1;
  logic [8:0]  left_dec;
  logic        el_put, sum_put;
  out_item_t   base, el_rec, sum_rec;
  logic [3:0]  status;
  logic [7:0]  pad;

  always_comb begin
    b = item.data_byte;
    if (item.packet_length == 12'd0) begin
      len_clamped = 12'd1;
    end else if (item.packet_length > 12'(MAX_PACKET_BYTES)) begin
      len_clamped = 12'(MAX_PACKET_BYTES);
    end else begin
      len_clamped = item.packet_length;
    end
    cur      = item.start_of_packet ? '0 : st;
    plen_cur = item.start_of_packet ? len_clamped : plen;
    take     = accept && (item.start_of_packet || active);
    p        = cur.pos;
    p18      = 19'(p);
    st_next  = cur;

    // Fixed header capture.
    if (p == 11'd0) begin
      st_next.hb0 = b;
    end else if (p == 11'd1) begin
      st_next.hb1 = b;
    end else if (p < 11'd4) begin
      st_next.seq = {cur.seq[7:0], b};
    end else if (p < 11'd8) begin
      st_next.ts = {cur.ts[23:0], b};
    end else if (p < 11'd12) begin
      st_next.ssrc = {cur.ssrc[23:0], b};
    end

    hs18     = 19'd12 + 19'({st_next.hb0[3:0], 2'b00});
    ext      = st_next.hb0[4];
    prof_new = {cur.profile[7:0], b};

    // Extension profile and length words.
    if (ext && p18 >= hs18 && p18 < hs18 + 19'd4) begin
      case (2'(p18 - hs18))
        2'd0: st_next.profile = {8'h00, b};
        2'd1: begin
          st_next.profile = prof_new;
          if (prof_new != PROFILE_ONE_BYTE && prof_new[15:4] != PROFILE_TWO_BYTE) begin
            st_next.err = ST_PROFILE;
          end
        end
        2'd2: st_next.ext_end = 19'(b);
        default: st_next.ext_end = hs18 + 19'd4 + 19'({cur.ext_end[7:0], b, 2'b00});
      endcase
    end

    is_rtcp   = st_next.hb1 >= rtcp_low && st_next.hb1 <= rtcp_high;
    plen18    = 19'(plen_cur);
    prefix_ok = plen_cur >= 12'd12 && st_next.hb0[7:6] == RTP_VERSION && !is_rtcp &&
                plen18 >= hs18;
    one_byte  = st_next.profile == PROFILE_ONE_BYTE;
    if (!ext || one_byte) begin
      prof_bits = 5'd0;
    end else begin
      prof_bits = {st_next.profile[15:4] == PROFILE_TWO_BYTE, st_next.profile[3:0]};
    end

    base = '0;
    base.marker_and_type = st_next.hb1;
    base.csrc_count      = st_next.hb0[3:0];
    base.sequence_number = st_next.seq;
    base.timestamp       = st_next.ts;
    base.ssrc            = st_next.ssrc;

    // Extension element walk.
    el_put    = 1'b0;
    el_rec    = base;
    el_rec.extension_profile = prof_bits;
    len1      = {1'b0, b[3:0]} + 5'd1;
    left_dec  = cur.left - 9'd1;
    in_window = ext && prefix_ok && p18 >= hs18 + 19'd4 && p18 < st_next.ext_end &&
                plen18 >= st_next.ext_end && st_next.err == ST_OK && !cur.stopped;
    if (in_window) begin
      case (cur.phase)
        PH_HEADER: begin
          if (b != 8'd0) begin
            if (one_byte) begin
              if (b[7:4] == ID_STOP) begin
                st_next.stopped    = 1'b1;
                el_put             = 1'b1;
                el_rec.record_kind = KIND_STOP;
                el_rec.element_id  = {4'd0, ID_STOP};
                el_rec.span_length = 12'(st_next.ext_end - p18);
                el_rec.span_offset = p;
              end else if (p18 + 19'd1 + 19'(len1) > st_next.ext_end) begin
                st_next.err = ST_ELEM_LEN;
              end else begin
                st_next.el_id    = {4'd0, b[7:4]};
                st_next.left     = 9'(len1);
                st_next.el_start = p + 11'd1;
                st_next.phase    = PH_DATA;
              end
            end else if (st_next.ext_end - p18 < 19'd2) begin
              st_next.err = ST_ELEM_LEN;
            end else begin
              st_next.el_id = b;
              st_next.phase = PH_LENGTH;
            end
          end
        end
        PH_LENGTH: begin
          if (p18 + 19'd1 + 19'(b) > st_next.ext_end) begin
            st_next.err   = ST_ELEM_LEN;
            st_next.phase = PH_HEADER;
          end else if (b == 8'd0) begin
            el_put             = 1'b1;
            el_rec.record_kind = KIND_ELEMENT;
            el_rec.element_id  = cur.el_id;
            st_next.phase      = PH_HEADER;
          end else begin
            st_next.left     = {1'b0, b};
            st_next.el_start = p + 11'd1;
            st_next.phase    = PH_DATA;
          end
        end
        default: begin
          st_next.left = left_dec;
          if (left_dec == 9'd0) begin
            el_put             = 1'b1;
            el_rec.record_kind = KIND_ELEMENT;
            el_rec.element_id  = cur.el_id;
            el_rec.span_length = {1'b0, p} + 12'd1 - {1'b0, cur.el_start};
            el_rec.span_offset = cur.el_start;
            st_next.phase      = PH_HEADER;
          end
        end
      endcase
    end

    // Summary at the last byte, checks in priority order.
    last      = {1'b0, p} + 12'd1 >= plen_cur;
    hdr_end18 = ext ? st_next.ext_end : hs18;
    pad       = st_next.hb0[5] ? b : 8'd0;
    if (plen_cur < 12'd12) begin
      status = ST_SHORT;
    end else if (st_next.hb0[7:6] != RTP_VERSION) begin
      status = ST_VERSION;
    end else if (is_rtcp) begin
      status = ST_RTCP;
    end else if (plen18 < hs18) begin
      status = ST_CSRC;
    end else if (ext && (plen18 < hs18 + 19'd4 || plen18 < st_next.ext_end)) begin
      status = ST_EXT;
    end else if (st_next.hb0[5] && pad == 8'd0) begin
      status = ST_ZERO_PAD;
    end else if (st_next.hb0[5] && plen18 < hdr_end18 + 19'(pad)) begin
      status = ST_PAD_OVF;
    end else begin
      status = st_next.err;
    end
    sum_put = last;
    sum_rec = base;
    sum_rec.record_kind = KIND_SUMMARY;
    sum_rec.status      = status;
    if (status == ST_OK || status >= ST_PROFILE) begin
      sum_rec.span_length       = 12'(plen18 - (hdr_end18 + 19'(pad)));
      sum_rec.span_offset       = 11'(hdr_end18);
      sum_rec.padding_length    = pad;
      sum_rec.extension_profile = prof_bits;
    end

    active_next = active;
    if (take) begin
      if (last) begin
        active_next = 1'b0;
      end else begin
        active_next = 1'b1;
        st_next.pos = p + 11'd1;
      end
    end

    recs.valid0 = take && (el_put || sum_put);
    recs.valid1 = take && el_put && sum_put;
    recs.rec0   = el_put ? el_rec : sum_rec;
    recs.rec1   = sum_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      plen   <= 12'd0;
      st     <= '0;
    end else begin
      active <= active_next;
      if (take) begin
        plen <= plen_cur;
        st   <= st_next;
      end
    end
  end

  a_two_then_summary: assert property (@(posedge clk) disable iff (rst)
    recs.valid1 |-> recs.rec1.record_kind == KIND_SUMMARY &&
                    recs.rec0.record_kind != KIND_SUMMARY)
    else $error("second record of a byte is not the summary");

  a_status_only_in_summary: assert property (@(posedge clk) disable iff (rst)
    (recs.valid0 && recs.rec0.record_kind != KIND_SUMMARY) |-> recs.rec0.status == ST_OK)
    else $error("element record carries a status");

  a_close_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> !active)
    else $error("packet still open after its last byte");

endmodule
`default_nettype wire

FILE: src/rtphp_fifo.sv
// Result queue: takes up to two records per cycle, delivers one per cycle while out_stall is low.
// Depends on rtphp_pkg.
`default_nettype none
module rtphp_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rtphp_pkg::rec_pair_t recs,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rtphp_pkg::out_item_t      out_item
);
  import rtphp_pkg::*;

  out_item_t           entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  rd_ptr, wr_ptr, wr_ptr1;
  logic [FIFO_AW:0]    count, count_next;
  logic                pop;
  logic [1:0]          push_n;

  always_comb begin
    full       = count > (FIFO_AW+1)'(FIFO_DEPTH - 2);
    out_valid  = count != '0;
    out_item   = entries[rd_ptr];
    pop        = out_valid && !out_stall;
    push_n     = {1'b0, recs.valid0} + {1'b0, recs.valid1};
    wr_ptr1    = wr_ptr + 1'b1;
    count_next = count + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (recs.valid0) begin
      entries[wr_ptr] <= recs.rec0;
    end
    if (recs.valid1) begin
      entries[wr_ptr1] <= recs.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/rtp_header_and_extension_parser_core.sv
// Top level of the RTP header and extension parser: configuration registers,
// the per-byte decoder and the result queue. Depends on rtphp_pkg.
//
// Usage: packet bytes enter on the in channel (in_valid / in_stall / in_item),
// one byte per item, the first flagged by start_of_packet together with the
// packet length. Records leave on the out channel (out_valid / out_stall /
// out_item): one for each complete extension element, one where a one-byte
// element with ID 15 stops parsing, and a summary at the last byte.
// Throughput is one byte per cycle while in_stall is low; each byte is decoded
// in the cycle it is accepted and its records enter a four-entry queue, whose
// registered head is offered on the out channel. A byte yields at most two
// records, so the input stalls whenever fewer than two queue entries are free;
// the queue drains one record per cycle unless the receiver stalls, in which
// case the queued records hold and bytes are still taken while room remains.
// Reset (rst, synchronous) closes any open packet, empties the queue and sets
// the RTCP range to 192..223. Configuration writes (cfg_write_enable,
// cfg_index, cfg_data) take effect at the next edge and are meant for idle.
`default_nettype none
module rtp_header_and_extension_parser_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rtphp_pkg::in_item_t   in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rtphp_pkg::out_item_t       out_item,
  input  wire logic                  cfg_write_enable,
  input  wire logic                  cfg_index,
  input  wire logic [7:0]            cfg_data
);
  import rtphp_pkg::*;

  logic [7:0] rtcp_low, rtcp_high;
  logic       full;
  logic       accept;
  rec_pair_t  recs;

  // Bytes are taken whenever the queue has room for a worst-case pair.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtcp_low  <= 8'd192;
      rtcp_high <= 8'd223;
    end else if (cfg_write_enable) begin
      if (cfg_index == CFG_RTCP_LOW) begin
        rtcp_low <= cfg_data;
      end else if (cfg_index == CFG_RTCP_HIGH) begin
        rtcp_high <= cfg_data;
      end
    end
  end

  rtphp_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_item),
    .rtcp_low  (rtcp_low),
    .rtcp_high (rtcp_high),
    .recs      (recs)
  );

  rtphp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .recs      (recs),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
